[src/pcbc_pkg.sv]
// Shared types, constants and arithmetic helpers of the point cloud statistics block.
package pcbc_pkg;

   localparam int WARMUP_POINTS_DEF = 3;

   localparam int COORD_W    = 32;
   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 32;
   localparam int DEN_W      = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int QIDX_W     = 4;
   localparam int AXES       = 3;
   localparam int NUM_PAIRS  = 6;
   localparam int ELEM_W     = 3;
   localparam int DIV_LANES  = 9;
   localparam int COV_LANE0  = AXES;
   localparam int DIV_STEPS  = VALUE_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      OP_ADD          = 2'd0,
      OP_QUERY        = 2'd1,
      OP_RESET_BOUNDS = 2'd2,
      OP_FULL_RESET   = 2'd3
   } opcode_type;

   // register index of stats_enable, taken from paddr[2]
   localparam logic REG_STATS_ENABLE = 1'b0;

   localparam logic [QIDX_W-1:0] QI_COUNT  = 4'd0;
   localparam logic [QIDX_W-1:0] QI_MIN_X  = 4'd1;
   localparam logic [QIDX_W-1:0] QI_MAX_X  = 4'd4;
   localparam logic [QIDX_W-1:0] QI_MEAN_X = 4'd7;
   localparam logic [QIDX_W-1:0] QI_COV_XX = 4'd10;
   localparam logic [QIDX_W-1:0] QI_LAST   = 4'd15;

   localparam logic [ELEM_W-1:0] LAST_PAIR = ELEM_W'(NUM_PAIRS - 1);

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam value_type COV_DIAG_RESET = 64'sh3B9ACA00_00000000;

   // upper triangle order xx xy xz yy yz zz
   localparam logic [1:0] PAIR_ROW [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_COL [NUM_PAIRS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
   localparam logic       PAIR_DIAG [NUM_PAIRS] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

   typedef struct packed {
      logic             accept;
      opcode_type       op;
      logic             mode_init;
      logic             dold_load;
      logic             clr_sum;
      logic             sum_step;
      logic             div_start;
      logic             div_phase_b;
      logic             mean_upd;
      logic             clr_acc;
      logic             diff_step;
      logic             mul_step;
      logic             acc_step;
      logic             cov_upd;
      logic             stage_write;
      logic             rsp_load;
      logic [ELEM_W-1:0] elem;
      logic [QIDX_W-1:0] rsp_index;
   } ctrl_cmd_type;

   typedef struct packed {
      logic stats_ready;
      logic need_init;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

   // signed value from sign and magnitude, clamped to the 64-bit range
   function automatic value_type from_mag(input logic neg, input logic [VALUE_W-1:0] m);
      value_type r;
      if (neg) begin
         r = m[VALUE_W-1] ? VALUE_MIN : -$signed(m);
      end else begin
         r = m[VALUE_W-1] ? VALUE_MAX : $signed(m);
      end
      return r;
   endfunction

   function automatic value_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_W:0] s;
      value_type r;
      s = (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         r = s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
      end else begin
         r = s[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/pcbc_div.sv]
// Multi-lane restoring divider, one quotient bit per cycle, rounds half away from zero.
module pcbc_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  pcbc_pkg::value_type                     num [pcbc_pkg::DIV_LANES],
   input  logic [pcbc_pkg::DEN_W-1:0]              den [pcbc_pkg::DIV_LANES],
   output logic                                    done,
   output pcbc_pkg::value_type                     quot [pcbc_pkg::DIV_LANES]
);
   import pcbc_pkg::*;

   logic [VALUE_W-1:0]   mag_ff [DIV_LANES];
   logic [DEN_W-1:0]     rem_ff [DIV_LANES];
   logic [DEN_W-1:0]     den_ff [DIV_LANES];
   logic                 neg_ff [DIV_LANES];
   value_type            quot_ff [DIV_LANES];
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 fin_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < DIV_LANES; l++) begin
         logic [DEN_W:0]   trial;
         logic             rnd;
         logic [VALUE_W-1:0] q;
         trial = {rem_ff[l], mag_ff[l][VALUE_W-1]};
         rnd   = rem_ff[l] >= (den_ff[l] - (den_ff[l] >> 1));
         q     = mag_ff[l] + VALUE_W'(rnd);
         if (start) begin
            mag_ff[l] <= num[l][VALUE_W-1] ? -num[l] : num[l];
            neg_ff[l] <= num[l][VALUE_W-1];
            rem_ff[l] <= '0;
            den_ff[l] <= (den[l] == '0) ? DEN_W'(1) : den[l];
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff[l]}) begin
               rem_ff[l] <= DEN_W'(trial - {1'b0, den_ff[l]});
               mag_ff[l] <= {mag_ff[l][VALUE_W-2:0], 1'b1};
            end else begin
               rem_ff[l] <= trial[DEN_W-1:0];
               mag_ff[l] <= {mag_ff[l][VALUE_W-2:0], 1'b0};
            end
         end
         if (fin_ff) begin
            quot_ff[l] <= from_mag(neg_ff[l], q);
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !fin_ff)
      else $error("divider started while busy");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> done_ff)
      else $error("divider result not flagged");
   a_fin_after_run: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> fin_ff)
      else $error("divider stopped without result");
`endif

endmodule

[src/pcbc_datapath.sv]
// Datapath: bounds, count, staging store, mean and covariance arithmetic, result register.
module pcbc_datapath #(
   parameter int  WARMUP_POINTS = pcbc_pkg::WARMUP_POINTS_DEF,
   localparam int IdxW = $clog2(WARMUP_POINTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcbc_pkg::ctrl_cmd_type        cmd,
   input  logic [IdxW-1:0]               cmd_pidx,
   input  pcbc_pkg::coord_type           req_x_coord,
   input  pcbc_pkg::coord_type           req_y_coord,
   input  pcbc_pkg::coord_type           req_z_coord,
   input  logic                          rsp_ready,
   output pcbc_pkg::dp_status_type       sts,
   output logic [IdxW-1:0]               sts_fill,
   output logic                          rsp_valid,
   output logic [pcbc_pkg::QIDX_W-1:0]   rsp_quantity_index,
   output pcbc_pkg::value_type           rsp_quantity_value,
   output logic                          rsp_last_of_run
);
   import pcbc_pkg::*;

   localparam int Slots = WARMUP_POINTS - 1;
   localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
   localparam int SumW  = COORD_W + IdxW;

   coord_type               bmin_ff [AXES];
   coord_type               bmax_ff [AXES];
   coord_type               mean_ff [AXES];
   value_type               cov_ff [NUM_PAIRS];
   logic [COUNT_W-1:0]      count_ff;
   logic                    ready_ff;
   logic [IdxW-1:0]         fill_ff;
   coord_type               stage_ff [Slots][AXES];
   coord_type               pt_ff [AXES];
   logic signed [DIFF_W-1:0] dold_ff [AXES];
   logic signed [SumW-1:0]  sum_ff [AXES];
   logic [COORD_W-1:0]      maga_ff;
   logic [COORD_W-1:0]      magb_ff;
   logic                    neg_ff;
   logic [VALUE_W-1:0]      prod_ff;
   logic                    pneg_ff;
   value_type               acc_ff [NUM_PAIRS];
   logic                    rsp_valid_ff;
   logic [QIDX_W-1:0]       rsp_index_ff;
   value_type               rsp_value_ff;
   logic                    rsp_last_ff;

   coord_type               req_coord [AXES];
   coord_type               pt_sel [AXES];
   logic [1:0]              row;
   logic [1:0]              col;
   logic signed [DIFF_W-1:0] da;
   logic signed [DIFF_W-1:0] db;
   logic [DIFF_W-1:0]       da_mag;
   logic [DIFF_W-1:0]       db_mag;
   logic [DEN_W-1:0]        k_den;
   logic [DEN_W-1:0]        km1_den;
   logic [DEN_W-1:0]        m_den;
   value_type               div_num [DIV_LANES];
   logic [DEN_W-1:0]        div_den [DIV_LANES];
   value_type               quot [DIV_LANES];
   logic                    div_done;
   value_type               rsp_value_in;
   logic [QIDX_W-1:0]       qoff;

   assign req_coord[0] = req_x_coord;
   assign req_coord[1] = req_y_coord;
   assign req_coord[2] = req_z_coord;

   // staged entry for points taken so far, the current point last
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pt_sel[a] = (cmd.mode_init && (cmd_pidx < fill_ff))
                   ? stage_ff[cmd_pidx[SlotW-1:0]][a] : pt_ff[a];
      end
   end

   assign row    = PAIR_ROW[cmd.elem];
   assign col    = PAIR_COL[cmd.elem];
   assign da     = cmd.mode_init ? (DIFF_W'(pt_sel[row]) - DIFF_W'(mean_ff[row]))
                                 : dold_ff[row];
   assign db     = DIFF_W'(pt_sel[col]) - DIFF_W'(mean_ff[col]);
   assign da_mag = da[DIFF_W-1] ? -da : da;
   assign db_mag = db[DIFF_W-1] ? -db : db;

   assign k_den   = DEN_W'(fill_ff) + DEN_W'(1);
   assign km1_den = (fill_ff == '0) ? DEN_W'(1) : DEN_W'(fill_ff);
   assign m_den   = (count_ff > COUNT_W'(1)) ? count_ff - COUNT_W'(1) : DEN_W'(1);

   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         div_num[l] = '0;
         div_den[l] = DEN_W'(1);
      end
      if (!cmd.div_phase_b) begin
         for (int a = 0; a < AXES; a++) begin
            div_num[a] = cmd.mode_init ? VALUE_W'(sum_ff[a]) : VALUE_W'(dold_ff[a]);
            div_den[a] = cmd.mode_init ? k_den : count_ff;
         end
         for (int e = 0; e < NUM_PAIRS; e++) begin
            div_num[COV_LANE0 + e] = cov_ff[e];
            div_den[COV_LANE0 + e] = m_den;
         end
      end else begin
         for (int e = 0; e < NUM_PAIRS; e++) begin
            div_num[e] = acc_ff[e];
            div_den[e] = cmd.mode_init ? km1_den : m_den;
         end
      end
   end

   pcbc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            bmin_ff[a] <= COORD_MAX;
            bmax_ff[a] <= COORD_MIN;
            mean_ff[a] <= '0;
         end
         for (int e = 0; e < NUM_PAIRS; e++) begin
            cov_ff[e] <= PAIR_DIAG[e] ? COV_DIAG_RESET : '0;
         end
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            unique case (cmd.op)
               OP_ADD: begin
                  for (int a = 0; a < AXES; a++) begin
                     if (req_coord[a] < bmin_ff[a]) bmin_ff[a] <= req_coord[a];
                     if (req_coord[a] > bmax_ff[a]) bmax_ff[a] <= req_coord[a];
                  end
                  if (count_ff != COUNT_MAX) count_ff <= count_ff + 1'b1;
               end
               OP_QUERY: begin
               end
               OP_RESET_BOUNDS: begin
                  for (int a = 0; a < AXES; a++) begin
                     bmin_ff[a] <= COORD_MAX;
                     bmax_ff[a] <= COORD_MIN;
                  end
               end
               OP_FULL_RESET: begin
                  for (int a = 0; a < AXES; a++) begin
                     bmin_ff[a] <= COORD_MAX;
                     bmax_ff[a] <= COORD_MIN;
                  end
                  count_ff <= '0;
                  ready_ff <= 1'b0;
                  fill_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.stage_write) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.mean_upd) begin
            for (int a = 0; a < AXES; a++) begin
               mean_ff[a] <= cmd.mode_init ? quot[a][COORD_W-1:0]
                                           : mean_ff[a] + quot[a][COORD_W-1:0];
            end
            if (!cmd.mode_init) begin
               for (int e = 0; e < NUM_PAIRS; e++) begin
                  cov_ff[e] <= cov_ff[e] - quot[COV_LANE0 + e];
               end
            end
         end
         if (cmd.cov_upd) begin
            for (int e = 0; e < NUM_PAIRS; e++) begin
               cov_ff[e] <= cmd.mode_init ? quot[e] : sat_add(cov_ff[e], quot[e]);
            end
            if (cmd.mode_init) begin
               ready_ff <= 1'b1;
               fill_ff  <= '0;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept && (cmd.op == OP_ADD)) begin
         for (int a = 0; a < AXES; a++) pt_ff[a] <= req_coord[a];
      end
      if (cmd.stage_write) begin
         for (int a = 0; a < AXES; a++) stage_ff[fill_ff[SlotW-1:0]][a] <= pt_ff[a];
      end
      if (cmd.dold_load) begin
         for (int a = 0; a < AXES; a++) begin
            dold_ff[a] <= DIFF_W'(pt_ff[a]) - DIFF_W'(mean_ff[a]);
         end
      end
      if (cmd.clr_sum) begin
         for (int a = 0; a < AXES; a++) sum_ff[a] <= '0;
      end else if (cmd.sum_step) begin
         for (int a = 0; a < AXES; a++) sum_ff[a] <= sum_ff[a] + SumW'(pt_sel[a]);
      end
      if (cmd.diff_step) begin
         maga_ff <= da_mag[COORD_W-1:0];
         magb_ff <= db_mag[COORD_W-1:0];
         neg_ff  <= da[DIFF_W-1] ^ db[DIFF_W-1];
      end
      if (cmd.mul_step) begin
         prod_ff <= VALUE_W'(maga_ff) * VALUE_W'(magb_ff);
         pneg_ff <= neg_ff;
      end
      if (cmd.clr_acc) begin
         for (int e = 0; e < NUM_PAIRS; e++) acc_ff[e] <= '0;
      end else if (cmd.acc_step) begin
         acc_ff[cmd.elem] <= sat_add(acc_ff[cmd.elem], from_mag(pneg_ff, prod_ff));
      end
      if (cmd.rsp_load) begin
         rsp_index_ff <= cmd.rsp_index;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= (cmd.rsp_index == QI_LAST);
      end
   end

   always_comb begin
      qoff = '0;
      priority if (cmd.rsp_index == QI_COUNT) begin
         rsp_value_in = VALUE_W'(count_ff);
      end else if (cmd.rsp_index < QI_MAX_X) begin
         qoff = cmd.rsp_index - QI_MIN_X;
         rsp_value_in = VALUE_W'(bmin_ff[qoff[1:0]]);
      end else if (cmd.rsp_index < QI_MEAN_X) begin
         qoff = cmd.rsp_index - QI_MAX_X;
         rsp_value_in = VALUE_W'(bmax_ff[qoff[1:0]]);
      end else if (cmd.rsp_index < QI_COV_XX) begin
         qoff = cmd.rsp_index - QI_MEAN_X;
         rsp_value_in = VALUE_W'(mean_ff[qoff[1:0]]);
      end else begin
         qoff = cmd.rsp_index - QI_COV_XX;
         rsp_value_in = cov_ff[qoff[2:0]];
      end
   end

   assign sts.stats_ready = ready_ff;
   assign sts.need_init   = (count_ff >= COUNT_W'(WARMUP_POINTS)) || (fill_ff >= IdxW'(Slots));
   assign sts.div_done    = div_done;
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign sts_fill        = fill_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quantity_index = rsp_index_ff;
   assign rsp_quantity_value = rsp_value_ff;
   assign rsp_last_of_run    = rsp_last_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= IdxW'(Slots))
      else $error("staging fill beyond its slots");
   a_stage_not_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.stage_write |-> !ready_ff)
      else $error("point staged after statistics were set");
   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_index_ff == QI_LAST)
      else $error("last flag on wrong quantity");
`endif

endmodule

[src/pcbc_ctrl.sv]
// Controller: request dispatch, warm-up and update sequencing, query result sequencing.
module pcbc_ctrl #(
   parameter int  WARMUP_POINTS = pcbc_pkg::WARMUP_POINTS_DEF,
   localparam int IdxW = $clog2(WARMUP_POINTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_opcode,
   output logic                     req_ready,
   input  logic                     stats_enable,
   input  pcbc_pkg::dp_status_type  sts,
   input  logic [IdxW-1:0]          sts_fill,
   output pcbc_pkg::ctrl_cmd_type   cmd,
   output logic [IdxW-1:0]          cmd_pidx
);
   import pcbc_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_POINT = 12'b0000_0000_0010,
      S_SUM   = 12'b0000_0000_0100,
      S_DIVA  = 12'b0000_0000_1000,
      S_WAITA = 12'b0000_0001_0000,
      S_DIFF  = 12'b0000_0010_0000,
      S_MUL   = 12'b0000_0100_0000,
      S_ACC   = 12'b0000_1000_0000,
      S_DIVB  = 12'b0001_0000_0000,
      S_WAITB = 12'b0010_0000_0000,
      S_QUERY = 12'b0100_0000_0000,
      S_SPARE = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [IdxW-1:0]   pidx_ff, pidx_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [QIDX_W-1:0] qidx_ff, qidx_in;
   logic              mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      pidx_in  = pidx_ff;
      elem_in  = elem_ff;
      qidx_in  = qidx_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.op        = opcode_type'(req_opcode);
      cmd.mode_init = mode_ff;
      cmd.elem      = elem_ff;
      cmd.rsp_index = qidx_ff;
      req_ready     = (state_ff == S_IDLE);
      cmd.accept    = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               if (cmd.op == OP_ADD) begin
                  state_in = S_POINT;
               end else if (cmd.op == OP_QUERY) begin
                  state_in = S_QUERY;
                  qidx_in  = QI_COUNT;
               end
            end
         end
         S_POINT: begin
            priority if (!stats_enable) begin
               state_in = S_IDLE;
            end else if (sts.stats_ready) begin
               cmd.dold_load = 1'b1;
               mode_in  = 1'b0;
               state_in = S_DIVA;
            end else if (sts.need_init) begin
               cmd.clr_sum = 1'b1;
               mode_in  = 1'b1;
               pidx_in  = '0;
               state_in = S_SUM;
            end else begin
               cmd.stage_write = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (pidx_ff == sts_fill) begin
               state_in = S_DIVA;
            end else begin
               pidx_in = pidx_ff + 1'b1;
            end
         end
         S_DIVA: begin
            cmd.div_start = 1'b1;
            state_in = S_WAITA;
         end
         S_WAITA: begin
            if (sts.div_done) begin
               cmd.mean_upd = 1'b1;
               cmd.clr_acc  = 1'b1;
               elem_in  = '0;
               pidx_in  = '0;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff_step = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            priority if (mode_ff && (pidx_ff != sts_fill)) begin
               pidx_in  = pidx_ff + 1'b1;
               state_in = S_DIFF;
            end else if (elem_ff == LAST_PAIR) begin
               state_in = S_DIVB;
            end else begin
               elem_in  = elem_ff + 1'b1;
               pidx_in  = '0;
               state_in = S_DIFF;
            end
         end
         S_DIVB: begin
            cmd.div_start   = 1'b1;
            cmd.div_phase_b = 1'b1;
            state_in = S_WAITB;
         end
         S_WAITB: begin
            cmd.div_phase_b = 1'b1;
            if (sts.div_done) begin
               cmd.cov_upd = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_QUERY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (qidx_ff == QI_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  qidx_in = qidx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cmd_pidx = pidx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pidx_ff  <= '0;
         elem_ff  <= '0;
         qidx_ff  <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pidx_ff  <= pidx_in;
         elem_ff  <= elem_in;
         qidx_ff  <= qidx_in;
         mode_ff  <= mode_in;
      end
   end

`ifndef ASSERT_OFF
   a_add_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (req_opcode == OP_ADD) |=> state_ff == S_POINT)
      else $error("point request not dispatched");
   a_diff_after_mean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAITA) && sts.div_done |=> state_ff == S_DIFF)
      else $error("products not started after mean update");
   a_query_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && (qidx_ff == QI_LAST) |=> state_ff == S_IDLE)
      else $error("query run did not end after last quantity");
   a_pidx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) || (state_ff == S_DIFF) || (state_ff == S_MUL) ||
      (state_ff == S_ACC) |-> pidx_ff <= sts_fill)
      else $error("point index past staged points");
`endif

endmodule

[src/point_cloud_bounds_and_covariance_core.sv]
// A query gives its 16 results one per cycle while the receiver takes them; an add with
// statistics off or a staged add returns to idle from the point state. An add with running
// statistics makes two divider passes (64 steps, rounding, done) with a difference, multiply
// and accumulate step for each of the six pairs between them; the point that sets them also
// sums the points in the set and runs those steps for every one of them.
// Reset (synchronous, active high) restores bounds, count, mean, covariance and stats_enable.
module point_cloud_bounds_and_covariance_core #(
   parameter int WARMUP_POINTS = pcbc_pkg::WARMUP_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  pcbc_pkg::coord_type               req_x_coord,
   input  pcbc_pkg::coord_type               req_y_coord,
   input  pcbc_pkg::coord_type               req_z_coord,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pcbc_pkg::QIDX_W-1:0]       rsp_quantity_index,
   output pcbc_pkg::value_type               rsp_quantity_value,
   output logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pcbc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pcbc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import pcbc_pkg::*;

   localparam int IdxW = $clog2(WARMUP_POINTS);

   logic            stats_enable_ff;
   ctrl_cmd_type    cmd;
   dp_status_type   sts;
   logic [IdxW-1:0] cmd_pidx;
   logic [IdxW-1:0] sts_fill;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_enable_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STATS_ENABLE)) begin
         stats_enable_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == REG_STATS_ENABLE) ? CSR_DATA_W'(stats_enable_ff) : '0;

   pcbc_ctrl #(.WARMUP_POINTS(WARMUP_POINTS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_opcode   (req_opcode),
      .req_ready    (req_ready),
      .stats_enable (stats_enable_ff),
      .sts          (sts),
      .sts_fill     (sts_fill),
      .cmd          (cmd),
      .cmd_pidx     (cmd_pidx)
   );

   pcbc_datapath #(.WARMUP_POINTS(WARMUP_POINTS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cmd_pidx           (cmd_pidx),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_z_coord        (req_z_coord),
      .rsp_ready          (rsp_ready),
      .sts                (sts),
      .sts_fill           (sts_fill),
      .rsp_valid          (rsp_valid),
      .rsp_quantity_index (rsp_quantity_index),
      .rsp_quantity_value (rsp_quantity_value),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
